### sv/sltbl_pkg.sv
package sltbl_pkg;

    localparam int CMD_W    = 3;
    localparam int STATUS_W = 3;

    // command codes; code 7 is a no-op
    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR      = 3'd0,
        CMD_INSERT_AT  = 3'd1,
        CMD_READ_AT    = 3'd2,
        CMD_FIND       = 3'd3,
        CMD_ORD_INSERT = 3'd4,
        CMD_BSEARCH    = 3'd5,
        CMD_BINSERT    = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 3'd0,
        ST_FULL     = 3'd1,
        ST_BADPOS   = 3'd2,
        ST_EMPTY    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_DUP      = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ_WAIT,
        S_FIND,
        S_BS_RD,
        S_BS_CMP,
        S_SHIFT,
        S_FINISH
    } state_t;

endpackage

### sv/sorted_list_table_engine.sv
// Table of CAPACITY signed words with a fill count, one command per input
// word and one result word per command. Commands go through a small
// sequencer around a single-port-write, single-port-read table RAM and one
// shared comparator, so only one command is in flight. Clear, reject and
// unknown commands go straight to the result; read_at waits for the RAM
// read and find scans at most count entries. insert_at appends directly or
// moves k entries up (one entry per cycle) before writing; ordered insert
// writes directly on an empty table and otherwise moves the k entries above
// the key. Binary search reads and compares once per halving step. Binary
// insert rejects a full table, reports a duplicate after its search, else
// appends or moves k entries after its search. The slowest command is a
// binary insert at the front of a table one short of full. A finished result
// sits in an output register, so a new command is taken as soon as the
// sequencer is back in idle. Binary commands assume the table is kept
// sorted; on unsorted contents they still run the plain halving search.
// No clearing pass follows reset; the table is ready at once.
module sorted_list_table_engine #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32,
    localparam int POS_W     = $clog2(CAPACITY + 1),
    localparam int IN_W      = 3 + POS_W + DATA_WIDTH,
    localparam int OUT_W     = 3 + 2 * POS_W + DATA_WIDTH,
    localparam int IN_DW     = ((IN_W + 7) / 8) * 8,
    localparam int OUT_DW    = ((OUT_W + 7) / 8) * 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // command, position, value
    input  logic [IN_DW-1:0]  s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // status, found_position, read_value, fill_count
    output logic [OUT_DW-1:0] m_axis_tdata
);

    import sltbl_pkg::*;

    localparam int ADDR_W = $clog2(CAPACITY);

    // state and working registers
    state_t                  state_reg, state_next;
    cmd_t                    cmd_reg, cmd_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [DATA_WIDTH-1:0]   val_reg, val_next;
    logic [POS_W-1:0]        count_reg, count_next;
    logic [POS_W-1:0]        idx_reg, idx_next;
    logic [POS_W-1:0]        bound_reg, bound_next;
    logic [POS_W-1:0]        lo_reg, lo_next;
    logic [POS_W-1:0]        hx_reg, hx_next;
    logic                    pend_reg, pend_next;
    logic [ADDR_W-1:0]       pend_addr_reg, pend_addr_next;
    status_t                 res_status_reg, res_status_next;
    logic [POS_W-1:0]        res_pos_reg, res_pos_next;
    logic [DATA_WIDTH-1:0]   res_val_reg, res_val_next;

    // output word register
    logic                    out_valid_reg, out_valid_next;
    status_t                 out_status_reg, out_status_next;
    logic [POS_W-1:0]        out_pos_reg, out_pos_next;
    logic [DATA_WIDTH-1:0]   out_val_reg, out_val_next;
    logic [POS_W-1:0]        out_fill_reg, out_fill_next;

    // RAM port
    logic                    ram_we, ram_re;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [DATA_WIDTH-1:0]   ram_wdata, ram_rdata;

    // decoded input word
    cmd_t                    in_cmd;
    logic [POS_W-1:0]        in_pos;
    logic [DATA_WIDTH-1:0]   in_val;
    logic                    accept;

    // conditions shared by next-state and datapath
    logic                    tbl_full, tbl_empty;
    logic                    ins_pos_ok, rd_pos_ok;
    logic                    key_eq, key_lt, entry_gt;
    logic                    bs_live, ord_stop, at_bound;
    logic                    find_last, out_load;
    logic [POS_W:0]          mid_sum;
    logic [POS_W-1:0]        mid;

    assign in_cmd = cmd_t'(s_axis_tdata[2:0]);
    assign in_pos = s_axis_tdata[3 +: POS_W];
    assign in_val = s_axis_tdata[3 + POS_W +: DATA_WIDTH];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign tbl_full   = (count_reg == POS_W'(CAPACITY));
    assign tbl_empty  = (count_reg == '0);
    assign ins_pos_ok = (in_pos != '0) && ({1'b0, in_pos} <= {1'b0, count_reg} + 1'b1);
    assign rd_pos_ok  = (in_pos != '0) && (in_pos <= count_reg);

    // shared comparator against the key
    assign key_eq   = (ram_rdata == val_reg);
    assign key_lt   = ($signed(val_reg) < $signed(ram_rdata));
    assign entry_gt = key_lt;

    // halving search midpoint: (lo + hi) / 2 with hi = hx - 1
    assign bs_live = (lo_reg < hx_reg);
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hx_reg} - 1'b1;
    assign mid     = mid_sum[POS_W:1];

    assign ord_stop  = pend_reg && (cmd_reg == CMD_ORD_INSERT) && !entry_gt;
    assign at_bound  = (idx_reg == bound_reg);
    assign find_last = ({1'b0, pend_addr_reg} + 1'b1 == {1'b0, count_reg});
    assign out_load  = !out_valid_reg || m_axis_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (in_cmd)
                        CMD_INSERT_AT:
                            state_next = (!tbl_full && ins_pos_ok) ? S_SHIFT : S_FINISH;
                        CMD_READ_AT:
                            state_next = (!tbl_empty && rd_pos_ok) ? S_READ_WAIT : S_FINISH;
                        CMD_FIND:
                            state_next = tbl_empty ? S_FINISH : S_FIND;
                        CMD_ORD_INSERT:
                            state_next = tbl_full ? S_FINISH : S_SHIFT;
                        CMD_BSEARCH:
                            state_next = S_BS_RD;
                        CMD_BINSERT:
                            state_next = tbl_full ? S_FINISH : S_BS_RD;
                        default:
                            state_next = S_FINISH;
                    endcase
                end
            end
            S_READ_WAIT:
                state_next = S_FINISH;
            S_FIND:
            begin
                if (pend_reg && (key_eq || find_last))
                begin
                    state_next = S_FINISH;
                end
            end
            S_BS_RD:
            begin
                if (bs_live)
                begin
                    state_next = S_BS_CMP;
                end
                else
                begin
                    state_next = (cmd_reg == CMD_BINSERT) ? S_SHIFT : S_FINISH;
                end
            end
            S_BS_CMP:
                state_next = key_eq ? S_FINISH : S_BS_RD;
            S_SHIFT:
            begin
                if (ord_stop || (!pend_reg && at_bound))
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath, RAM controls and result
    always_comb
    begin
        cmd_next        = cmd_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        bound_next      = bound_reg;
        lo_next         = lo_reg;
        hx_next         = hx_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        res_status_next = res_status_reg;
        res_pos_next    = res_pos_reg;
        res_val_next    = res_val_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_val_next    = out_val_reg;
        out_fill_next   = out_fill_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = val_reg;
        ram_re          = 1'b0;
        ram_raddr       = '0;

        // output word handed over
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next        = in_cmd;
                    pos_next        = in_pos;
                    val_next        = in_val;
                    res_status_next = ST_OK;
                    res_pos_next    = '0;
                    res_val_next    = '0;
                    idx_next        = count_reg;
                    pend_next       = 1'b0;
                    lo_next         = '0;
                    hx_next         = count_reg;
                    unique case (in_cmd)
                        CMD_CLEAR:
                            count_next = '0;
                        CMD_INSERT_AT:
                        begin
                            if (tbl_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (!ins_pos_ok)
                            begin
                                res_status_next = ST_BADPOS;
                            end
                            bound_next = in_pos - 1'b1;
                        end
                        CMD_READ_AT:
                        begin
                            if (tbl_empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else if (!rd_pos_ok)
                            begin
                                res_status_next = ST_BADPOS;
                            end
                            else
                            begin
                                ram_re    = 1'b1;
                                ram_raddr = ADDR_W'(in_pos - 1'b1);
                            end
                        end
                        CMD_FIND:
                        begin
                            if (tbl_empty)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            idx_next = '0;
                        end
                        CMD_ORD_INSERT:
                        begin
                            if (tbl_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                            bound_next = '0;
                        end
                        CMD_BINSERT:
                        begin
                            if (tbl_full)
                            begin
                                res_status_next = ST_FULL;
                            end
                        end
                        default:
                            ;
                    endcase
                end
            end

            // registered RAM data for read_at
            S_READ_WAIT:
            begin
                res_val_next = ram_rdata;
                res_pos_next = pos_reg;
            end

            // linear scan, one read issued per cycle
            S_FIND:
            begin
                if (idx_reg < count_reg)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = idx_reg[ADDR_W-1:0];
                    idx_next       = idx_reg + 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = idx_reg[ADDR_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (key_eq)
                    begin
                        res_pos_next = POS_W'(pend_addr_reg) + 1'b1;
                    end
                    else if (find_last)
                    begin
                        res_status_next = ST_NOTFOUND;
                    end
                end
            end

            // halving search: issue the midpoint read
            S_BS_RD:
            begin
                if (bs_live)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = mid[ADDR_W-1:0];
                    idx_next  = mid;
                end
                else if (cmd_reg == CMD_BINSERT)
                begin
                    bound_next = lo_reg;
                    idx_next   = count_reg;
                    pend_next  = 1'b0;
                end
                else
                begin
                    res_status_next = ST_NOTFOUND;
                end
            end

            // halving search: compare and narrow
            S_BS_CMP:
            begin
                if (key_eq)
                begin
                    res_pos_next    = idx_reg + 1'b1;
                    res_status_next = (cmd_reg == CMD_BINSERT) ? ST_DUP : ST_OK;
                end
                else if (key_lt)
                begin
                    hx_next = idx_reg;
                end
                else
                begin
                    lo_next = idx_reg + 1'b1;
                end
            end

            // move entries up one place, then drop the new word in
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pend_addr_reg + 1'b1;
                    ram_wdata = ord_stop ? val_reg : ram_rdata;
                    if (ord_stop)
                    begin
                        res_pos_next = POS_W'(pend_addr_reg) + POS_W'(2);
                        count_next   = count_reg + 1'b1;
                    end
                end
                else if (at_bound)
                begin
                    ram_we       = 1'b1;
                    ram_waddr    = idx_reg[ADDR_W-1:0];
                    ram_wdata    = val_reg;
                    res_pos_next = idx_reg + 1'b1;
                    count_next   = count_reg + 1'b1;
                end
                if (!ord_stop && !at_bound)
                begin
                    ram_re         = 1'b1;
                    ram_raddr      = ADDR_W'(idx_reg - 1'b1);
                    idx_next       = idx_reg - 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = ADDR_W'(idx_reg - 1'b1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
            end

            // hand the result to the output register
            S_FINISH:
            begin
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_pos_next    = res_pos_reg;
                    out_val_next    = res_val_reg;
                    out_fill_next   = count_reg;
                end
            end

            default:
                ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        idx_reg        <= idx_next;
        bound_reg      <= bound_next;
        lo_reg         <= lo_next;
        hx_reg         <= hx_next;
        pend_addr_reg  <= pend_addr_next;
        res_status_reg <= res_status_next;
        res_pos_reg    <= res_pos_next;
        res_val_reg    <= res_val_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_val_reg    <= out_val_next;
        out_fill_reg   <= out_fill_next;
    end

    // table storage
    sltbl_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_DW'({out_fill_reg, out_val_reg, out_pos_reg, out_status_reg});

endmodule

### sv/sltbl_ram.sv
module sltbl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### bench/tb_top.sv
module tb_top;

    import sltbl_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int POS_W      = 7;
    localparam int IN_W       = CMD_W + POS_W + DATA_WIDTH;
    localparam int OUT_W      = STATUS_W + 2 * POS_W + DATA_WIDTH;
    localparam int IN_DW      = ((IN_W + 7) / 8) * 8;
    localparam int OUT_DW     = ((OUT_W + 7) / 8) * 8;

    // code 7 has no member in cmd_t; the block must treat it as a no-op
    localparam logic [CMD_W-1:0] CMD_NOP = 3'd7;

    localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;

    localparam int MAX_GAP        = 17;
    localparam int DRAIN_CYCLES   = CAPACITY + 16;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        status_t               status;
        logic [POS_W-1:0]      found_pos;
        logic [DATA_WIDTH-1:0] read_val;
        logic [POS_W-1:0]      fill;
    } table_result_t;

    logic              clk           = 1'b0;
    logic              rst_n         = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // command, position, value
    logic [IN_DW-1:0]  s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // status, found_position, read_value, fill_count
    logic [OUT_DW-1:0] m_axis_tdata;

    // table model state
    logic signed [DATA_WIDTH-1:0] tbl_q [CAPACITY];
    int                           fill = 0;

    table_result_t results_due [$];
    table_result_t want_r;
    int            errors       = 0;
    int            src_calm     = 0;
    int            snk_calm     = 0;
    int            stall_left   = 0;
    int            quiet_cycles = 0;

    sorted_list_table_engine #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // gap before a word: 0..17, with the odd stretch of back-to-back words
    function automatic int pick_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
            calm = $urandom_range(8, 40);
        return $urandom_range(0, MAX_GAP);
    endfunction

    // make room at slot and write v there
    function automatic void shift_in(int slot, logic signed [DATA_WIDTH-1:0] v);
        for (int i = fill; i > slot; i--)
            tbl_q[i] = tbl_q[i-1];
        tbl_q[slot] = v;
        fill++;
    endfunction

    // plain halving search; slot is the match or the insertion point
    function automatic bit halving_search(logic signed [DATA_WIDTH-1:0] key,
                                          output int slot);
        int lo = 0;
        int hi = fill - 1;
        int mid;
        while (lo <= hi)
        begin
            mid = (lo + hi) / 2;
            if (key == tbl_q[mid])
            begin
                slot = mid;
                return 1'b1;
            end
            else if (key < tbl_q[mid])
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        slot = lo;
        return 1'b0;
    endfunction

    // apply one command to the model table and return the result word
    function automatic table_result_t predict_table(logic [CMD_W-1:0] cmd,
                                                    logic [POS_W-1:0] pos,
                                                    logic signed [DATA_WIDTH-1:0] val);
        table_result_t r;
        int            slot;
        r.status    = ST_OK;
        r.found_pos = '0;
        r.read_val  = '0;
        slot        = 0;
        case (cmd)
            CMD_CLEAR:
                fill = 0;
            CMD_INSERT_AT:
                if (fill >= CAPACITY)
                    r.status = ST_FULL;
                else if (pos < 1 || pos > fill + 1)
                    r.status = ST_BADPOS;
                else
                begin
                    shift_in(int'(pos) - 1, val);
                    r.found_pos = pos;
                end
            CMD_READ_AT:
                if (fill == 0)
                    r.status = ST_EMPTY;
                else if (pos < 1 || pos > fill)
                    r.status = ST_BADPOS;
                else
                begin
                    r.read_val  = tbl_q[pos-1];
                    r.found_pos = pos;
                end
            CMD_FIND:
                if (fill == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    while (slot < fill && tbl_q[slot] != val)
                        slot++;
                    if (slot < fill)
                        r.found_pos = POS_W'(slot + 1);
                    else
                        r.status = ST_NOTFOUND;
                end
            CMD_ORD_INSERT:
                if (fill >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    // land after any equal entries
                    slot = fill - 1;
                    while (slot >= 0 && tbl_q[slot] > val)
                        slot--;
                    shift_in(slot + 1, val);
                    r.found_pos = POS_W'(slot + 2);
                end
            CMD_BSEARCH:
                if (halving_search(val, slot))
                    r.found_pos = POS_W'(slot + 1);
                else
                    r.status = ST_NOTFOUND;
            CMD_BINSERT:
                if (fill >= CAPACITY)
                    r.status = ST_FULL;
                else if (halving_search(val, slot))
                begin
                    r.status    = ST_DUP;
                    r.found_pos = POS_W'(slot + 1);
                end
                else
                begin
                    shift_in(slot, val);
                    r.found_pos = POS_W'(slot + 1);
                end
            default:
                ;
        endcase
        r.fill = POS_W'(fill);
        return r;
    endfunction

    // keys: stored entries, a small cluster round zero, extremes, anything
    function automatic logic signed [DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 5))
            0, 1:
                if (fill > 0)
                    return tbl_q[$urandom_range(0, fill - 1)];
                else
                    return $urandom;
            2:       return int'($urandom_range(0, 16)) - 8;
            3:       return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
            default: return $urandom;
        endcase
    endfunction

    // one command word; valid stays high across back-to-back words
    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                             input logic signed [DATA_WIDTH-1:0] val);
        int gap;
        gap = pick_gap(src_calm);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        results_due.push_back(predict_table(cmd, pos, val));
        s_axis_tdata  <= {{(IN_DW - IN_W){1'b0}}, val, pos, cmd};
        s_axis_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // hold the sender off until every result word is back
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_empty_table();
        send_word(CMD_READ_AT, 7'd1, 32'sd0);
        send_word(CMD_FIND, 7'd0, 32'sd0);
        send_word(CMD_BSEARCH, 7'd0, 32'sd0);
        send_word(CMD_INSERT_AT, 7'd0, 32'sd1);
        send_word(CMD_INSERT_AT, 7'd2, 32'sd1);
    endtask

    task automatic test_positional_ops();
        send_word(CMD_INSERT_AT, 7'd1, VAL_MAX);
        send_word(CMD_INSERT_AT, 7'd1, VAL_MIN);
        send_word(CMD_READ_AT, 7'd0, 32'sd0);
        send_word(CMD_READ_AT, 7'd3, 32'sd0);
        send_word(CMD_READ_AT, 7'd127, 32'sd0);
        send_word(CMD_READ_AT, 7'd1, 32'sd0);
        send_word(CMD_READ_AT, 7'd2, 32'sd0);
        send_word(CMD_FIND, 7'd0, VAL_MAX);
        send_word(CMD_FIND, 7'd0, 32'sd0);
    endtask

    task automatic test_ordered_ops();
        // equal keys go after the existing one
        send_word(CMD_ORD_INSERT, 7'd0, -32'sd1);
        send_word(CMD_ORD_INSERT, 7'd0, -32'sd1);
        send_word(CMD_BSEARCH, 7'd0, -32'sd1);
        send_word(CMD_BSEARCH, 7'd0, 32'sd5);
        send_word(CMD_BINSERT, 7'd0, 32'sd5);
        send_word(CMD_BINSERT, 7'd0, -32'sd1);
    endtask

    task automatic test_nop_and_clear();
        send_word(CMD_NOP, 7'd127, $urandom);
        send_word(CMD_INSERT_AT, 7'd6, 32'sd42);
        send_word(CMD_CLEAR, 7'd0, 32'sd0);
        send_word(CMD_READ_AT, 7'd1, 32'sd0);
    endtask

    // sorted use: the table fills to capacity, clears are rare
    task automatic test_sorted_workload(int n);
        int               sel;
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        repeat (n)
        begin
            sel = $urandom_range(0, 199);
            pos = (fill > 0) ? POS_W'($urandom_range(1, fill)) : 7'd1;
            if (sel == 0 || (fill == CAPACITY && sel < 50))
                cmd = CMD_CLEAR;
            else if (sel < 60)
                cmd = CMD_BINSERT;
            else if (sel < 100)
                cmd = CMD_ORD_INSERT;
            else if (sel < 140)
                cmd = CMD_BSEARCH;
            else if (sel < 170)
                cmd = CMD_FIND;
            else
                cmd = CMD_READ_AT;
            send_word(cmd, pos, pick_value());
        end
    endtask

    // any command, wild positions, unsorted contents
    task automatic test_mixed_noise(int n);
        logic [CMD_W-1:0] cmd;
        logic [POS_W-1:0] pos;
        repeat (n)
        begin
            if ($urandom_range(0, 79) == 0)
                cmd = CMD_CLEAR;
            else
                cmd = CMD_W'($urandom_range(1, 7));
            if ($urandom_range(0, 3) == 0)
                pos = POS_W'($urandom_range(0, 127));
            else
                pos = POS_W'($urandom_range(0, fill + 1));
            send_word(cmd, pos, pick_value());
        end
    endtask

    // result side back-pressure, one stall draw per word taken
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
            stall_left = pick_gap(snk_calm);
        else if (stall_left > 0)
            stall_left--;
        m_axis_tready <= (stall_left == 0);
    end

    // compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: result word with none due: %h", $time, m_axis_tdata);
                errors++;
            end
            else
            begin
                want_r = results_due.pop_front();
                if (m_axis_tdata[2:0] !== want_r.status)
                begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want_r.status, m_axis_tdata[2:0]);
                    errors++;
                end
                if (m_axis_tdata[9:3] !== want_r.found_pos)
                begin
                    $display("%0t: found_position expected %0d got %0d",
                             $time, want_r.found_pos, m_axis_tdata[9:3]);
                    errors++;
                end
                if (m_axis_tdata[41:10] !== want_r.read_val)
                begin
                    $display("%0t: read_value expected %h got %h",
                             $time, want_r.read_val, m_axis_tdata[41:10]);
                    errors++;
                end
                if (m_axis_tdata[48:42] !== want_r.fill)
                begin
                    $display("%0t: fill_count expected %0d got %0d",
                             $time, want_r.fill, m_axis_tdata[48:42]);
                    errors++;
                end
            end
        end
    end

    // stop a hung run
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_positional_ops();
        test_ordered_ops();
        test_nop_and_clear();
        test_sorted_workload(450);
        drain_results();
        test_sorted_workload(450);
        drain_results();
        test_mixed_noise(600);
        drain_results();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && results_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
